FILE: rtl/lstok_pkg.sv
// shared types and constants for the linker script tokenizer
package lstok_pkg;

  localparam int JOB_BYTES   = 4;
  localparam int AVAIL_W     = 3;
  localparam int FIELD_W     = 24;
  localparam int DOUT_W      = 8;
  localparam int LINE_W      = 24;
  localparam int CNT_W       = 3;
  localparam int JOB_Q_DEPTH = 4;
  localparam int OUT_Q_DEPTH = 4;

  localparam logic [LINE_W-1:0] LINE_MAX    = '1;
  localparam logic [CNT_W-1:0]  MAX_RESULTS = CNT_W'(4);

  typedef enum logic [1:0] {
    LM_DEFAULT,
    LM_COMMENT,
    LM_WORD,
    LM_NUMBER
  } lex_mode_t;

  typedef enum logic {
    FS_RUN,
    FS_FLUSH
  } front_state_t;

  typedef enum logic {
    JOB_DECIDE,
    JOB_CLOSE
  } job_kind_t;

  typedef enum logic [3:0] {
    TK_WORD        = 4'd0,
    TK_NUMBER      = 4'd1,
    TK_STRING      = 4'd2,
    TK_COMMENT     = 4'd3,
    TK_ASSIGN      = 4'd4,
    TK_OPERATOR    = 4'd5,
    TK_BRACE_OPEN  = 4'd6,
    TK_BRACE_CLOSE = 4'd7,
    TK_PAREN_OPEN  = 4'd8,
    TK_PAREN_CLOSE = 4'd9
  } tok_kind_t;

  typedef struct packed {
    job_kind_t                   kind;
    logic                        item_end;
    logic [AVAIL_W-1:0]          avail;
    logic [JOB_BYTES-1:0][7:0]   bytes;
  } job_t;

  typedef struct packed {
    tok_kind_t           kind;
    logic [FIELD_W-1:0]  start_pos;
    logic [FIELD_W-1:0]  token_length;
    logic [FIELD_W-1:0]  start_line;
    logic [FIELD_W-1:0]  end_line;
    logic [DOUT_W-1:0]   paren_depth;
    logic [DOUT_W-1:0]   scope_depth;
  } tok_t;

  typedef struct packed {
    tok_t tok;
    logic last;
  } out_item_t;

endpackage

FILE: rtl/lstok_fifo.sv
// small register queue with count based full and empty
module lstok_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/lstok_front.sv
// front end: lookahead window, flush sequencing and job issue
module lstok_front
  import lstok_pkg::*;
#(
  parameter int LOOKAHEAD = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       job_push,
  output job_t       job,
  input  logic       job_full
);

  localparam int FILL_W = $clog2(LOOKAHEAD + 1);
  localparam int IDX_W  = $clog2(LOOKAHEAD);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LOOKAHEAD);

  front_state_t      state;
  front_state_t      state_next;
  logic [7:0]        win [LOOKAHEAD];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              accept;
  logic              win_load;
  logic              win_shift;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      FS_RUN: begin
        if (accept && in_end) begin
          state_next = FS_FLUSH;
        end
      end
      FS_FLUSH: begin
        if (!job_full && fill == '0) begin
          state_next = FS_RUN;
        end
      end
      default: state_next = FS_RUN;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    job_push  = 1'b0;
    win_load  = 1'b0;
    win_shift = 1'b0;
    fill_next = fill;
    job.kind     = JOB_DECIDE;
    job.item_end = 1'b1;
    job.avail    = AVAIL_W'(LOOKAHEAD);
    for (int k = 0; k < JOB_BYTES - 1; k++) begin
      job.bytes[k] = win[k];
    end
    job.bytes[JOB_BYTES-1] = (LOOKAHEAD > JOB_BYTES - 1) ? win[LOOKAHEAD-1] : in_byte;
    case (state)
      FS_RUN: begin
        in_ready = !job_full;
        if (accept && !in_end) begin
          if (fill != FILL_FULL) begin
            win_load  = 1'b1;
            fill_next = fill + 1'b1;
          end else begin
            job_push  = 1'b1;
            win_shift = 1'b1;
          end
        end
      end
      FS_FLUSH: begin
        if (!job_full) begin
          job_push = 1'b1;
          if (fill != '0) begin
            job.item_end = 1'b0;
            job.avail    = AVAIL_W'(fill - 1'b1);
            job.bytes[JOB_BYTES-1] =
              (LOOKAHEAD > JOB_BYTES - 1) ? win[LOOKAHEAD-1] : 8'h00;
            win_shift = 1'b1;
            fill_next = fill - 1'b1;
          end else begin
            job.kind = JOB_CLOSE;
          end
        end
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_RUN;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (win_load) begin
      win[fill[IDX_W-1:0]] <= in_byte;
    end else if (win_shift) begin
      for (int k = 0; k < LOOKAHEAD - 1; k++) begin
        win[k] <= win[k+1];
      end
      win[LOOKAHEAD-1] <= in_byte;
    end
  end

endmodule

FILE: rtl/lstok_back.sv
// back end: lexer state, counters, token build and run marking
module lstok_back
  import lstok_pkg::*;
#(
  parameter int POSITION_BITS = 24,
  parameter int DEPTH_BITS    = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_pop,
  input  logic      out_room,
  output logic      out_push,
  output out_item_t out_item
);

  localparam int LEN_W = POSITION_BITS + 2;
  localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
  localparam logic [DEPTH_BITS-1:0]    DEPTH_MAX = '1;

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch inside {[8'h09:8'h0D]}) || ch == " ";
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch inside {["0":"9"]};
  endfunction

  function automatic logic word_start(input logic [7:0] ch);
    return (ch inside {["A":"Z"], ["a":"z"]}) ||
           (ch inside {"_", ">", ":", "?", "*", "[", "]", "/", "!", "."});
  endfunction

  function automatic logic number_body(input logic [7:0] ch);
    return (ch inside {"K", "M", "x", "X", "b", "B"}) ||
           (ch inside {["0":"9"], ["A":"F"], ["a":"f"]});
  endfunction

  function automatic logic is_op(input logic [7:0] ch);
    return ch inside {"*", ">", "<", "/", "-", "+", "&", "%", "=", "?", ":", ",",
                      ";", "~", "(", ")", "{", "}", "!"};
  endfunction

  lex_mode_t                mode;
  lex_mode_t                mode_next;
  logic [POSITION_BITS-1:0] byte_pos;
  logic [POSITION_BITS-1:0] tok_pos;
  logic [LINE_W-1:0]        tok_line;
  logic [LINE_W-1:0]        line_count;
  logic [DEPTH_BITS-1:0]    paren;
  logic [DEPTH_BITS-1:0]    scope;
  logic [1:0]               skip;
  logic [CNT_W-1:0]         cnt;
  tok_t                     held;
  logic                     held_v;
  logic                     held_final;

  logic [7:0]               c;
  logic [7:0]               b1;
  logic [7:0]               b2;
  logic [7:0]               b3;
  logic                     p1;
  logic                     p2;
  logic                     p3;
  logic                     go;
  logic                     is_close;
  logic                     skipping;
  logic                     body;
  logic                     tok_end;
  logic                     cmt_end;
  logic                     dflt;
  logic                     close_emit;
  logic                     consume;
  logic                     item_done;
  logic                     nt;
  logic                     push_held;

  logic [1:0]               asg_len;
  logic [2:0]               op_len;
  logic                     d_emit;
  logic                     d_open;
  lex_mode_t                d_mode;
  tok_kind_t                d_kind;
  logic [2:0]               d_len;

  tok_kind_t                t_kind;
  logic [POSITION_BITS-1:0] t_start;
  logic [LEN_W-1:0]         t_len_raw;
  logic [POSITION_BITS-1:0] t_len;
  logic [LINE_W-1:0]        t_sl;
  logic [LINE_W-1:0]        t_el;
  tok_t                     tok;

  assign c  = job.bytes[0];
  assign b1 = job.bytes[1];
  assign b2 = job.bytes[2];
  assign b3 = job.bytes[3];
  assign p1 = job.avail >= AVAIL_W'(1);
  assign p2 = job.avail >= AVAIL_W'(2);
  assign p3 = job.avail >= AVAIL_W'(3);

  assign go         = job_valid && out_room;
  assign is_close   = (job.kind == JOB_CLOSE);
  assign skipping   = !is_close && skip != 2'd0;
  assign body       = (mode == LM_WORD) ? (is_digit(c) || word_start(c)) : number_body(c);
  assign tok_end    = !is_close && !skipping && (mode == LM_WORD || mode == LM_NUMBER) && !body;
  assign cmt_end    = !is_close && !skipping && mode == LM_COMMENT && c == "*" &&
                      p1 && b1 == "/";
  assign dflt       = !is_close && !skipping && mode == LM_DEFAULT;
  assign close_emit = is_close && mode != LM_DEFAULT;
  assign consume    = !tok_end;
  assign item_done  = go && consume && job.item_end;
  assign job_pop    = go && consume;

  // assignment and long operator lengths at this position
  always_comb begin
    asg_len = 2'd0;
    if (c == "=") begin
      asg_len = (!p1 || is_ws(b1)) ? 2'd1 : 2'd0;
    end else if (c inside {"*", "/", "%", "-", "+"}) begin
      asg_len = (p2 && b1 == "=" && is_ws(b2)) ? 2'd2 : 2'd0;
    end
    op_len = 3'd0;
    if (c == ">" && p1 && b1 == ">" && p2 && b2 == "=" && p3 && b3 == " ") begin
      op_len = 3'd4;
    end else if (c == "<" && p1 && b1 == "<" && p2 && b2 == "=" && p3 && b3 == " ") begin
      op_len = 3'd4;
    end else if (c == "!" && p1 && b1 == "=" && p2 && b2 == " ") begin
      op_len = 3'd3;
    end else if (c == "=" && p1 && b1 == "=" && p2 && b2 == " ") begin
      op_len = 3'd3;
    end else if (c == ">" && p1 && b1 == ">" && p2 && b2 == " ") begin
      op_len = 3'd3;
    end
  end

  // decision for a byte seen in the default mode
  always_comb begin
    d_emit = 1'b0;
    d_open = 1'b0;
    d_mode = LM_WORD;
    d_kind = TK_OPERATOR;
    d_len  = 3'd1;
    if (!is_ws(c)) begin
      if (is_digit(c)) begin
        d_open = 1'b1;
        d_mode = LM_NUMBER;
      end else if (c == "/" && p1 && b1 == "*") begin
        d_open = 1'b1;
        d_mode = LM_COMMENT;
      end else if (c == "\"") begin
        d_emit = 1'b1;
        d_kind = TK_STRING;
      end else if (asg_len != 2'd0) begin
        d_emit = 1'b1;
        d_kind = TK_ASSIGN;
        d_len  = 3'(asg_len);
      end else if (word_start(c)) begin
        if (is_op(c) && op_len != 3'd0) begin
          d_emit = 1'b1;
          d_len  = op_len;
        end else begin
          d_open = 1'b1;
        end
      end else if (is_op(c)) begin
        d_emit = 1'b1;
        case (c)
          "{":     d_kind = TK_BRACE_OPEN;
          "}":     d_kind = TK_BRACE_CLOSE;
          "(":     d_kind = TK_PAREN_OPEN;
          ")":     d_kind = TK_PAREN_CLOSE;
          default: d_kind = TK_OPERATOR;
        endcase
      end
    end
  end

  always_comb begin
    mode_next = mode;
    if (go) begin
      if (is_close || tok_end || cmt_end) begin
        mode_next = LM_DEFAULT;
      end else if (dflt && d_open) begin
        mode_next = d_mode;
      end
    end
  end

  always_comb begin
    nt = go && (close_emit || tok_end || cmt_end || (dflt && d_emit)) && cnt < MAX_RESULTS;
    case (mode)
      LM_WORD:    t_kind = TK_WORD;
      LM_NUMBER:  t_kind = TK_NUMBER;
      LM_COMMENT: t_kind = TK_COMMENT;
      default:    t_kind = d_kind;
    endcase
    t_start = dflt ? byte_pos : tok_pos;
    if (dflt) begin
      t_len_raw = LEN_W'(d_len);
    end else if (cmt_end) begin
      t_len_raw = LEN_W'(byte_pos) + LEN_W'(2) - LEN_W'(tok_pos);
    end else begin
      t_len_raw = LEN_W'(byte_pos) - LEN_W'(tok_pos);
    end
    if (t_len_raw == '0) begin
      t_len = POSITION_BITS'(1);
    end else if (t_len_raw > LEN_W'(POS_MAX)) begin
      t_len = POS_MAX;
    end else begin
      t_len = t_len_raw[POSITION_BITS-1:0];
    end
    t_sl = dflt ? line_count : tok_line;
    t_el = (dflt || mode == LM_COMMENT) ? line_count : tok_line;
    tok.kind         = t_kind;
    tok.start_pos    = FIELD_W'(t_start);
    tok.token_length = FIELD_W'(t_len);
    tok.start_line   = FIELD_W'(t_sl);
    tok.end_line     = FIELD_W'(t_el);
    tok.paren_depth  = DOUT_W'(paren);
    tok.scope_depth  = DOUT_W'(scope);
  end

  // one token is held back until it is known whether it ends its item
  assign push_held     = out_room && held_v && (held_final || nt || item_done);
  assign out_push      = push_held;
  assign out_item.tok  = held;
  assign out_item.last = held_final || !nt;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= LM_DEFAULT;
      byte_pos   <= '0;
      tok_pos    <= '0;
      tok_line   <= '0;
      line_count <= LINE_W'(1);
      paren      <= '0;
      scope      <= '0;
      skip       <= 2'd0;
      cnt        <= '0;
      held_v     <= 1'b0;
      held_final <= 1'b0;
    end else begin
      mode <= mode_next;
      if (out_room) begin
        if (nt) begin
          held_v     <= 1'b1;
          held_final <= item_done;
        end else if (push_held) begin
          held_v <= 1'b0;
        end
      end
      if (go) begin
        cnt <= item_done ? '0 : cnt + CNT_W'(nt);
        if (is_close) begin
          byte_pos   <= '0;
          tok_pos    <= '0;
          tok_line   <= '0;
          line_count <= LINE_W'(1);
          paren      <= '0;
          scope      <= '0;
          skip       <= 2'd0;
        end else if (consume) begin
          if (byte_pos != POS_MAX) begin
            byte_pos <= byte_pos + 1'b1;
          end
          if (skipping) begin
            skip <= skip - 1'b1;
          end else begin
            if (cmt_end) begin
              skip <= 2'd1;
            end else if (dflt && d_emit) begin
              skip <= 2'(d_len - 3'd1);
            end
            if (dflt && d_open) begin
              tok_pos  <= byte_pos;
              tok_line <= line_count;
            end
            case (c)
              "\n": if (line_count != LINE_MAX) line_count <= line_count + 1'b1;
              "{":  if (scope != DEPTH_MAX) scope <= scope + 1'b1;
              "}":  if (scope != '0) scope <= scope - 1'b1;
              "(":  if (paren != DEPTH_MAX) paren <= paren + 1'b1;
              ")":  if (paren != '0) paren <= paren - 1'b1;
              default: line_count <= line_count;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_room && nt) begin
      held <= tok;
    end
  end

endmodule

FILE: rtl/linker_script_tokenizer_unit.sv
// top level of the linker script tokenizer
// path: a byte's tokens and an end marker's tokens pass the job queue, the held token register
//   and the output queue in that order; a byte that closes a word or number and also emits is
//   decided again by the back end, and tokens come later when earlier items are still queued
// throughput: one byte per cycle while the job queue has room;
//   an end marker stalls input until the window is flushed, the first LOOKAHEAD bytes give none
// reset: synchronous, empties the window, clears lexer state, counters and both queues
module linker_script_tokenizer_unit
  import lstok_pkg::*;
#(
  parameter int POSITION_BITS = 24,
  parameter int DEPTH_BITS    = 8,
  parameter int LOOKAHEAD     = 3
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // char_byte
  input  logic         s_tlast,   // end_of_stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // start_pos, token_length, start_line, end_line,
                                  // paren_depth, scope_depth
  output logic [3:0]   m_tuser,   // token_kind
  output logic         m_tlast    // last_of_run
);

  job_t      fj;
  logic      fj_push;
  logic      jq_full;
  logic      jq_empty;
  logic [$bits(job_t)-1:0] jq_data;
  job_t      bj;
  logic      bj_pop;
  logic      oq_full;
  logic      oq_empty;
  logic      oq_push;
  out_item_t oq_in;
  logic [$bits(out_item_t)-1:0] oq_data;
  out_item_t oq_out;

  lstok_front #(
    .LOOKAHEAD(LOOKAHEAD)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_end   (s_tlast),
    .job_push (fj_push),
    .job      (fj),
    .job_full (jq_full)
  );

  lstok_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(JOB_Q_DEPTH)
  ) u_job_q (
    .clk       (clk),
    .rst       (rst),
    .push      (fj_push),
    .push_data (fj),
    .full      (jq_full),
    .pop       (bj_pop),
    .pop_data  (jq_data),
    .empty     (jq_empty)
  );

  assign bj = job_t'(jq_data);

  lstok_back #(
    .POSITION_BITS(POSITION_BITS),
    .DEPTH_BITS   (DEPTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!jq_empty),
    .job       (bj),
    .job_pop   (bj_pop),
    .out_room  (!oq_full),
    .out_push  (oq_push),
    .out_item  (oq_in)
  );

  lstok_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_Q_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (oq_push),
    .push_data (oq_in),
    .full      (oq_full),
    .pop       (m_tvalid && m_tready),
    .pop_data  (oq_data),
    .empty     (oq_empty)
  );

  assign oq_out   = out_item_t'(oq_data);
  assign m_tvalid = !oq_empty;
  assign m_tuser  = oq_out.tok.kind;
  assign m_tlast  = oq_out.last;
  assign m_tdata  = {oq_out.tok.scope_depth, oq_out.tok.paren_depth, oq_out.tok.end_line,
                     oq_out.tok.start_line, oq_out.tok.token_length, oq_out.tok.start_pos};

endmodule

FILE: rtl/lstok_checker.sv
// port level checks for the tokenizer, bound to the top level
module lstok_props
  import lstok_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [7:0]   s_tdata,
  input logic         s_tlast,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata,
  input logic [3:0]   m_tuser,
  input logic         m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled token changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("token shown right after reset");

  a_flush_stall: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken during end of text flush");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= TK_PAREN_CLOSE)
    else $error("token kind out of range");

  a_line_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[71:48] != 24'd0 && m_tdata[95:72] >= m_tdata[71:48])
    else $error("token lines out of order");

endmodule

bind linker_script_tokenizer_unit lstok_props u_checker (.*);

FILE: bench/lstok_checker.sv
// token checker for the linker script tokenizer: predicts tokens per item and compares output
module lstok_checker
  import lstok_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,
  input  logic [3:0]   m_tuser,
  input  logic         m_tlast,
  output int           errors,
  output int           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     WIN             = 3;
  localparam longint POS_LIMIT       = 64'hFFFFFF;
  localparam int     TOKENS_PER_ITEM = 4;

  typedef logic [3:0][7:0] view_t;

  lex_mode_t   mode;
  logic [23:0] tok_pos;
  logic [23:0] tok_line;
  logic [23:0] line_no;
  logic [23:0] byte_pos;
  logic [7:0]  paren_lvl;
  logic [7:0]  scope_lvl;
  logic [7:0]  win [WIN];
  int          win_fill;
  int          skip_left;
  out_item_t   step_toks[$];
  out_item_t   expected_tokens[$];

  function automatic bit is_space(int c);
    return (c >= 9 && c <= 13) || c == 32;
  endfunction

  function automatic bit is_digit(int c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit word_start(int c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_" || c == ">" ||
           c == ":" || c == "?" || c == "*" || c == "[" || c == "]" || c == "/" ||
           c == "!" || c == ".";
  endfunction

  function automatic bit number_body(int c);
    return c == "K" || c == "M" || c == "x" || c == "X" || c == "b" || c == "B" ||
           is_digit(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic bit is_op(int c);
    return c == "*" || c == ">" || c == "<" || c == "/" || c == "-" || c == "+" ||
           c == "&" || c == "%" || c == "=" || c == "?" || c == ":" || c == "," ||
           c == ";" || c == "~" || c == "(" || c == ")" || c == "{" || c == "}" ||
           c == "!";
  endfunction

  function automatic int peek(view_t v, int avail, int k);
    if (k > avail || k > WIN) return -1;
    return int'(v[k]);
  endfunction

  function automatic void lex_reset();
    mode      = LM_DEFAULT;
    tok_pos   = '0;
    tok_line  = '0;
    line_no   = 24'd1;
    paren_lvl = '0;
    scope_lvl = '0;
    byte_pos  = '0;
    foreach (win[i]) win[i] = '0;
    win_fill  = 0;
    skip_left = 0;
  endfunction

  function automatic void add_token(tok_kind_t kind, longint start, longint len,
                                    logic [23:0] sl, logic [23:0] el);
    out_item_t t;
    longint    n;
    if (step_toks.size() >= TOKENS_PER_ITEM) return;
    n = len;
    if (n < 1) n = 1;
    if (n > POS_LIMIT) n = POS_LIMIT;
    t.tok.kind         = kind;
    t.tok.start_pos    = 24'(start);
    t.tok.token_length = 24'(n);
    t.tok.start_line   = sl;
    t.tok.end_line     = el;
    t.tok.paren_depth  = paren_lvl;
    t.tok.scope_depth  = scope_lvl;
    t.last             = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void open_tok(lex_mode_t m, longint pos);
    tok_pos  = 24'(pos);
    tok_line = line_no;
    mode     = m;
  endfunction

  function automatic int assign_len(view_t v, int avail);
    int c;
    c = v[0];
    if (c == "=") begin
      if (avail < 1) return 1;
      return is_space(peek(v, avail, 1)) ? 1 : 0;
    end
    if (c == "*" || c == "/" || c == "%" || c == "-" || c == "+") begin
      if (avail < 2 || peek(v, avail, 1) != "=") return 0;
      return is_space(peek(v, avail, 2)) ? 2 : 0;
    end
    return 0;
  endfunction

  // pattern chars are packed with the first char highest
  function automatic bit seq_at(view_t v, int avail, int n, logic [31:0] pat);
    for (int k = 0; k < n; k++)
      if (peek(v, avail, k) != int'(pat[8*(n-1-k) +: 8])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int long_op_len(view_t v, int avail);
    if (seq_at(v, avail, 4, ">>= ")) return 4;
    if (seq_at(v, avail, 4, "<<= ")) return 4;
    if (seq_at(v, avail, 3, "!= "))  return 3;
    if (seq_at(v, avail, 3, "== "))  return 3;
    if (seq_at(v, avail, 3, ">> "))  return 3;
    return 0;
  endfunction

  function automatic void count_update(int c);
    if (c == 10 && line_no != LINE_MAX) line_no++;
    else if (c == "{" && scope_lvl != 8'hFF) scope_lvl++;
    else if (c == "}" && scope_lvl != 8'h00) scope_lvl--;
    else if (c == "(" && paren_lvl != 8'hFF) paren_lvl++;
    else if (c == ")" && paren_lvl != 8'h00) paren_lvl--;
  endfunction

  function automatic void decide_default(view_t v, int avail, longint pos);
    int        c;
    int        n;
    tok_kind_t k;
    c = v[0];
    if (is_space(c)) return;
    if (is_digit(c)) begin
      open_tok(LM_NUMBER, pos);
      return;
    end
    if (c == "/" && peek(v, avail, 1) == "*") begin
      open_tok(LM_COMMENT, pos);
      return;
    end
    if (c == "\"") begin
      add_token(TK_STRING, pos, 1, line_no, line_no);
      return;
    end
    n = assign_len(v, avail);
    if (n != 0) begin
      add_token(TK_ASSIGN, pos, n, line_no, line_no);
      skip_left = n - 1;
      return;
    end
    if (word_start(c)) begin
      n = is_op(c) ? long_op_len(v, avail) : 0;
      if (n != 0) begin
        add_token(TK_OPERATOR, pos, n, line_no, line_no);
        skip_left = n - 1;
      end else begin
        open_tok(LM_WORD, pos);
      end
      return;
    end
    if (is_op(c)) begin
      k = (c == "{") ? TK_BRACE_OPEN : (c == "}") ? TK_BRACE_CLOSE :
          (c == "(") ? TK_PAREN_OPEN : (c == ")") ? TK_PAREN_CLOSE : TK_OPERATOR;
      add_token(k, pos, 1, line_no, line_no);
    end
  endfunction

  function automatic void decide(view_t v, int avail);
    int     c;
    longint pos;
    bit     done;
    c   = v[0];
    pos = longint'(byte_pos);
    if (skip_left > 0) begin
      skip_left--;
      if (byte_pos != 24'hFFFFFF) byte_pos++;
      return;
    end
    done = 1'b0;
    while (!done) begin
      if (mode == LM_WORD || mode == LM_NUMBER) begin
        if ((mode == LM_WORD) ? (is_digit(c) || word_start(c)) : number_body(c)) begin
          done = 1'b1;
        end else begin
          add_token((mode == LM_WORD) ? TK_WORD : TK_NUMBER, longint'(tok_pos),
                    pos - longint'(tok_pos), tok_line, tok_line);
          mode = LM_DEFAULT;
        end
      end else if (mode == LM_COMMENT) begin
        if (c == "*" && peek(v, avail, 1) == "/") begin
          add_token(TK_COMMENT, longint'(tok_pos), pos + 2 - longint'(tok_pos),
                    tok_line, line_no);
          mode      = LM_DEFAULT;
          skip_left = 1;
        end
        done = 1'b1;
      end else begin
        decide_default(v, avail, pos);
        done = 1'b1;
      end
    end
    count_update(c);
    if (byte_pos != 24'hFFFFFF) byte_pos++;
  endfunction

  function automatic void lex_step(logic [7:0] b, logic eos);
    view_t     v;
    int        rem;
    out_item_t t;
    step_toks.delete();
    if (eos) begin
      for (int i = 0; i < win_fill; i++) begin
        rem = win_fill - i;
        v   = '0;
        for (int j = 0; j < rem; j++) v[j] = win[i+j];
        decide(v, rem - 1);
      end
      if (mode != LM_DEFAULT)
        add_token((mode == LM_WORD) ? TK_WORD : (mode == LM_NUMBER) ? TK_NUMBER : TK_COMMENT,
                  longint'(tok_pos), longint'(byte_pos) - longint'(tok_pos), tok_line,
                  (mode == LM_COMMENT) ? line_no : tok_line);
      lex_reset();
    end else if (win_fill < WIN) begin
      win[win_fill] = b;
      win_fill++;
    end else begin
      v = {b, win[2], win[1], win[0]};
      decide(v, WIN);
      win[0] = win[1];
      win[1] = win[2];
      win[2] = b;
    end
    if (step_toks.size() > 0) begin
      t      = step_toks.pop_back();
      t.last = 1'b1;
      step_toks.push_back(t);
    end
    foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_token();
    out_item_t want;
    if (expected_tokens.size() == 0) begin
      errors++;
      $display("%0t: token expected none, got kind %0d tdata %h last %0b",
               $time, m_tuser, m_tdata, m_tlast);
      return;
    end
    want = expected_tokens.pop_front();
    check_field("token_kind", want.tok.kind, m_tuser);
    check_field("start_pos", want.tok.start_pos, m_tdata[23:0]);
    check_field("token_length", want.tok.token_length, m_tdata[47:24]);
    check_field("start_line", want.tok.start_line, m_tdata[71:48]);
    check_field("end_line", want.tok.end_line, m_tdata[95:72]);
    check_field("paren_depth", want.tok.paren_depth, m_tdata[103:96]);
    check_field("scope_depth", want.tok.scope_depth, m_tdata[111:104]);
    check_field("last_of_run", want.last, m_tlast);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      lex_reset();
      expected_tokens.delete();
    end else begin
      if (s_tvalid && s_tready) lex_step(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_token();
    end
    outstanding <= expected_tokens.size();
  end

endmodule

FILE: bench/tb_linker_script_tokenizer_unit.sv
// testbench top: feeds script text and end markers to the tokenizer and reports the verdict
module tb_linker_script_tokenizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 200;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 12;
  localparam int DEPTH_RUN    = 40;

  logic         clk;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata  = 8'h00;
  logic         s_tlast  = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic [3:0]   m_tuser;
  logic         m_tlast;

  int         tok_errors;
  int         tok_outstanding;
  int         cycle_count = 0;
  int         items_sent  = 0;
  int         stall_left  = 0;
  bit         no_gaps     = 1'b0;
  bit         ready_free  = 1'b0;
  logic [7:0] text_buf[$];

  linker_script_tokenizer_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  lstok_checker tok_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .errors      (tok_errors),
    .outstanding (tok_outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!ready_free && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [7:0] any_of(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void put_char(logic [7:0] c);
    text_buf.push_back(c);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  function automatic void put_fragment();
    string s;
    case ($urandom_range(0, 11))
      0, 1: begin
        put_char(any_of("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
        repeat ($urandom_range(0, 6)) put_char(any_of("abcxyzKLM_.0123456789"));
      end
      2: begin
        if ($urandom_range(0, 1)) begin
          put_str("0x");
          repeat ($urandom_range(1, 6)) put_char(any_of("0123456789abcdefABCDEF"));
        end else begin
          repeat ($urandom_range(1, 5)) put_char(any_of("0123456789"));
        end
        if ($urandom_range(0, 3) == 0) put_char(any_of("KM"));
      end
      3: put_char(any_of(" \n\t\r\v\f"));
      4: put_char(any_of("*<>/-+&%=?:,;~!"));
      5: begin
        case ($urandom_range(0, 7))
          0: s = ">>= ";
          1: s = "<<= ";
          2: s = "!= ";
          3: s = "== ";
          4: s = ">> ";
          5: s = ">>=";
          6: s = "!=";
          default: s = ">>x";
        endcase
        put_str(s);
      end
      6: begin
        case ($urandom_range(0, 6))
          0: s = "= ";
          1: s = "+= ";
          2: s = "-= ";
          3: s = "*= ";
          4: s = "/= ";
          5: s = "%= ";
          default: s = "=x";
        endcase
        put_str(s);
      end
      7: put_char(any_of("{}()"));
      8: begin
        put_str("/*");
        repeat ($urandom_range(0, 10)) put_char(any_of("ab *\n/{("));
        put_str("*/");
      end
      9: put_char("\"");
      11: begin
        put_char(any_of("abcxyz"));
        put_char(any_of("0129"));
        put_char(any_of("(){};,=+-\""));
      end
      default: put_char(8'($urandom));
    endcase
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eos);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = no_gaps ? 0 : (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_text(input bit with_end);
    foreach (text_buf[i]) send_item(text_buf[i], 1'b0);
    if (with_end) send_item(8'($urandom), 1'b1);
    text_buf.delete();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tok_outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int target;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // end marker on an empty window, then a short mixed text
    send_item(8'hA5, 1'b1);
    put_str("ab) >>= 0xF{\n/*/ ");
    put_char(8'hFF);
    put_char(8'h00);
    put_str("\"+= ");
    send_text(1'b1);
    wait_drained();

    // deep nesting, then one closing paren and one closing brace
    ready_free = 1'b1;
    no_gaps    = 1'b1;
    repeat (DEPTH_RUN) put_str("({");
    put_str(" a)}");
    send_text(1'b1);
    wait_drained();

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      no_gaps    = ($urandom_range(0, 4) == 0);
      ready_free = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(5, 30)) put_char(8'($urandom));
      end else begin
        repeat ($urandom_range(2, 14)) begin
          put_fragment();
          if ($urandom_range(0, 1)) put_char(any_of(" \n\t\r\v\f"));
        end
        if ($urandom_range(0, 5) == 0) put_str($urandom_range(0, 1) ? "/*x" : "id9");
      end
      send_text($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    send_item(8'($urandom), 1'b1);

    @(negedge clk);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tok_outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tok_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lstok_pkg.sv
rtl/lstok_fifo.sv
rtl/lstok_front.sv
rtl/lstok_back.sv
rtl/linker_script_tokenizer_unit.sv
rtl/lstok_checker.sv
bench/lstok_checker.sv
bench/tb_linker_script_tokenizer_unit.sv
